// File: design/ssbd_pkg.sv
// Shared types, constants and the opcode layout table of the sound-script decoder.
package ssbd_pkg;

   localparam int OFFSET_BITS    = 16;
   localparam int INSTR_OFFSET_W = 16;
   localparam int ARG_W          = 32;
   localparam int NUM_ARGS       = 3;

   typedef logic [1:0] slot_type;

   localparam slot_type NO_SLOT = 2'd3;

   // len of zero marks an invalid opcode
   typedef struct packed {
      logic [4:0] len;
      slot_type   byte1;
      slot_type   half2;
      slot_type   word0;
      slot_type   word1;
      slot_type   word2;
   } layout_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_OPCODE = 2'd1,
      STATUS_TRUNCATED  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
      logic       stream_end;
   } req_word_type;

   typedef struct packed {
      logic [INSTR_OFFSET_W-1:0] instr_offset;
      logic [7:0]                opcode_value;
      logic signed [ARG_W-1:0]   arg_first;
      logic signed [ARG_W-1:0]   arg_second;
      logic signed [ARG_W-1:0]   arg_third;
      status_type                status;
   } rsp_word_type;

   function automatic layout_type op_layout(input logic [4:0] op);
      layout_type lay;
      lay = '{5'd0, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
      case (op)
         5'h00, 5'h09, 5'h0a, 5'h10, 5'h15, 5'h17, 5'h19, 5'h1d:
            lay = '{5'd4, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
         5'h02, 5'h04:
            lay = '{5'd4, 2'd0, 2'd1, NO_SLOT, NO_SLOT, NO_SLOT};
         5'h05:
            lay = '{5'd12, NO_SLOT, NO_SLOT, 2'd0, 2'd1, NO_SLOT};
         5'h06, 5'h11, 5'h12, 5'h16, 5'h18, 5'h1a, 5'h1c:
            lay = '{5'd8, NO_SLOT, NO_SLOT, 2'd0, NO_SLOT, NO_SLOT};
         5'h08, 5'h1b:
            lay = '{5'd16, NO_SLOT, NO_SLOT, 2'd0, 2'd1, 2'd2};
         5'h0b, 5'h13:
            lay = '{5'd4, 2'd0, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
         5'h0c, 5'h14:
            lay = '{5'd4, NO_SLOT, 2'd0, NO_SLOT, NO_SLOT, NO_SLOT};
         5'h0d:
            lay = '{5'd8, NO_SLOT, 2'd0, 2'd1, NO_SLOT, NO_SLOT};
         5'h0e:
            lay = '{5'd12, NO_SLOT, 2'd0, 2'd1, 2'd2, NO_SLOT};
         default:
            lay = '{5'd0, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
      endcase
      return lay;
   endfunction

endpackage

// File: design/ssbd_req_if.sv
// Byte input channel: valid/ready handshake carrying one stream byte and its flags.
interface ssbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_start;
   logic       stream_end;

   modport source (output valid, data_byte, stream_start, stream_end, input ready);
   modport sink   (input valid, data_byte, stream_start, stream_end, output ready);
endinterface

// File: design/ssbd_rsp_if.sv
// Result channel: valid/ready handshake carrying one decoded instruction.
interface ssbd_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        instr_offset;
   logic [7:0]         opcode_value;
   logic signed [31:0] arg_first;
   logic signed [31:0] arg_second;
   logic signed [31:0] arg_third;
   logic [1:0]         status;

   modport source (output valid, instr_offset, opcode_value, arg_first, arg_second,
                   arg_third, status, input ready);
   modport sink   (input valid, instr_offset, opcode_value, arg_first, arg_second,
                   arg_third, status, output ready);
endinterface

// File: design/sound_script_bytecode_decoder_unit.sv
// Top level: input word register, decode core and result register of the decoder.
//
//  channel   | dir | word                                   | handshake
//  ----------+-----+----------------------------------------+-------------
//  req_chan  | in  | data_byte, stream_start, stream_end    | valid/ready
//  rsp_chan  | out | instr_offset, opcode_value, args, status | valid/ready
//
// One byte per cycle while the result channel is not stalled; after its last byte is taken,
// a result passes the input register and then the result register before it is offered.
// Synchronous active-high reset clears the decode state and both valid flags.
// A stalled result holds the core; the input register then fills and req ready drops.
module sound_script_bytecode_decoder_unit (
   input  logic     clock,
   input  logic     reset,
   ssbd_req_if.sink   req_chan,
   ssbd_rsp_if.source rsp_chan
);
   import ssbd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   logic         advance;
   logic         req_take;
   logic         core_emit;
   rsp_word_type core_rsp;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = core_emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   ssbd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_word  (in_word_ff),
      .emit     (core_emit),
      .rsp_word (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= '{req_chan.data_byte, req_chan.stream_start, req_chan.stream_end};
      end
      if (advance && core_emit) begin
         rsp_word_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.instr_offset = rsp_word_ff.instr_offset;
   assign rsp_chan.opcode_value = rsp_word_ff.opcode_value;
   assign rsp_chan.arg_first    = rsp_word_ff.arg_first;
   assign rsp_chan.arg_second   = rsp_word_ff.arg_second;
   assign rsp_chan.arg_third    = rsp_word_ff.arg_third;
   assign rsp_chan.status       = rsp_word_ff.status;

   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff)
      else $error("pending result dropped");

   a_no_advance_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("core advanced while result register blocked");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid flags not cleared by reset");

endmodule

// File: design/ssbd_core.sv
// Decode state and per-byte field insertion; produces at most one result per byte.
module ssbd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ssbd_pkg::req_word_type in_word,
   output logic                 emit,
   output ssbd_pkg::rsp_word_type rsp_word
);
   import ssbd_pkg::*;

   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [3:0]             idx_ff, idx_in;
   logic [4:0]             opc_ff, opc_in;
   logic [ARG_W-1:0]       arg_ff [NUM_ARGS];
   logic [ARG_W-1:0]       arg_in [NUM_ARGS];
   logic                   halted_ff, halted_in;

   logic [OFFSET_BITS-1:0] pos;
   logic [3:0]             idx_cur;
   logic                   halt_cur;
   layout_type             lay;
   layout_type             cur_lay;
   slot_type               slot;
   logic [1:0]             lane;
   logic [ARG_W-1:0]       ins;
   logic [ARG_W-1:0]       arg_new [NUM_ARGS];
   logic [4:0]             next_idx;
   logic [7:0]             b;

   assign cur_lay = op_layout(opc_ff);

   always_comb begin
      b        = in_word.data_byte;
      pos      = in_word.stream_start ? '0 : off_ff;
      idx_cur  = in_word.stream_start ? 4'd0 : idx_ff;
      halt_cur = in_word.stream_start ? 1'b0 : halted_ff;
      lay      = cur_lay;

      // byte lane and argument slot for this position
      slot = NO_SLOT;
      lane = 2'd0;
      if (idx_cur == 4'd1) begin
         slot = lay.byte1;
      end else if (idx_cur < 4'd4) begin
         slot = lay.half2;
         lane = {1'b0, idx_cur[0]};
      end else begin
         lane = idx_cur[1:0];
         case (idx_cur[3:2])
            2'd1:    slot = lay.word0;
            2'd2:    slot = lay.word1;
            2'd3:    slot = lay.word2;
            default: slot = NO_SLOT;
         endcase
      end
      ins = ARG_W'(b) << {lane, 3'b000};
      if (idx_cur == 4'd3 && b[7]) begin
         ins = ins | 32'hFFFF_0000;  // sign-extend the 16-bit word
      end
      for (int k = 0; k < NUM_ARGS; k++) begin
         arg_new[k] = (slot == 2'(k)) ? (arg_ff[k] | ins) : arg_ff[k];
      end
      next_idx = {1'b0, idx_cur} + 5'd1;

      off_in    = off_ff;
      start_in  = start_ff;
      idx_in    = idx_cur;
      opc_in    = opc_ff;
      halted_in = halt_cur;
      for (int k = 0; k < NUM_ARGS; k++) begin
         arg_in[k] = arg_ff[k];
      end
      emit     = 1'b0;
      rsp_word = '{INSTR_OFFSET_W'(start_ff), {3'b000, opc_ff}, '0, '0, '0, STATUS_TRUNCATED};

      if (in_word.stream_start) begin
         off_in = '0;
      end

      if (!halt_cur) begin
         off_in = pos + OFFSET_BITS'(1);
         if (idx_cur == 4'd0) begin
            if (b[7:5] != 3'd0 || op_layout(b[4:0]).len == 5'd0) begin
               emit      = 1'b1;
               rsp_word  = '{INSTR_OFFSET_W'(pos), b, '0, '0, '0, STATUS_BAD_OPCODE};
               halted_in = 1'b1;
            end else begin
               opc_in   = b[4:0];
               start_in = pos;
               for (int k = 0; k < NUM_ARGS; k++) begin
                  arg_in[k] = '0;
               end
               idx_in = 4'd1;
               if (in_word.stream_end) begin
                  emit      = 1'b1;
                  rsp_word  = '{INSTR_OFFSET_W'(pos), b, '0, '0, '0, STATUS_TRUNCATED};
                  idx_in    = 4'd0;
                  halted_in = 1'b1;
               end
            end
         end else begin
            for (int k = 0; k < NUM_ARGS; k++) begin
               arg_in[k] = arg_new[k];
            end
            if (next_idx >= lay.len) begin
               emit      = 1'b1;
               rsp_word  = '{INSTR_OFFSET_W'(start_ff), {3'b000, opc_ff}, arg_new[0],
                             arg_new[1], arg_new[2], STATUS_OK};
               idx_in    = 4'd0;
               halted_in = in_word.stream_end;
            end else begin
               idx_in = next_idx[3:0];
               if (in_word.stream_end) begin
                  emit      = 1'b1;
                  idx_in    = 4'd0;
                  halted_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff    <= '0;
         idx_ff    <= 4'd0;
         halted_ff <= 1'b0;
      end else if (advance) begin
         off_ff    <= off_in;
         idx_ff    <= idx_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff <= start_in;
         opc_ff   <= opc_in;
         for (int k = 0; k < NUM_ARGS; k++) begin
            arg_ff[k] <= arg_in[k];
         end
      end
   end

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      advance && halted_ff && !in_word.stream_start |-> !emit)
      else $error("result produced while halted");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      advance && emit && rsp_word.status != STATUS_OK |=> halted_ff)
      else $error("decoder not halted after error result");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 4'd0 |-> ({1'b0, idx_ff} < cur_lay.len))
      else $error("byte index beyond instruction length");

endmodule
